[src/i2cms_pkg.sv]
// ----------------------------------------------------------------------------
// i2cms_pkg
// Shared constants for the I2C master bit sequencer: widths, command codes,
// phase codes, register map and reset values.
// ----------------------------------------------------------------------------
package i2cms_pkg;

  // field widths
  localparam int unsigned ModeW   = 3;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned TickW   = 12;
  localparam int unsigned TmoW    = 8;
  localparam int unsigned DelayW  = 13;
  localparam int unsigned BitCntW = 4;
  localparam int unsigned PhaseW  = 4;
  localparam int unsigned ApbAw   = 3;
  localparam int unsigned ApbDw   = 32;

  // command codes
  localparam logic [ModeW-1:0] CmdStart    = 3'd0;
  localparam logic [ModeW-1:0] CmdStop     = 3'd1;
  localparam logic [ModeW-1:0] CmdSendByte = 3'd2;
  localparam logic [ModeW-1:0] CmdWaitAck  = 3'd3;
  localparam logic [ModeW-1:0] CmdReadByte = 3'd4;

  // sequencer phases
  localparam logic [PhaseW-1:0] PhIdle   = 4'd0;
  localparam logic [PhaseW-1:0] PhStA    = 4'd1;
  localparam logic [PhaseW-1:0] PhStB    = 4'd2;
  localparam logic [PhaseW-1:0] PhSpA    = 4'd3;
  localparam logic [PhaseW-1:0] PhSpB    = 4'd4;
  localparam logic [PhaseW-1:0] PhSpC    = 4'd5;
  localparam logic [PhaseW-1:0] PhWaA    = 4'd6;
  localparam logic [PhaseW-1:0] PhWaB    = 4'd7;
  localparam logic [PhaseW-1:0] PhWaPoll = 4'd8;
  localparam logic [PhaseW-1:0] PhSbLow  = 4'd9;
  localparam logic [PhaseW-1:0] PhSbData = 4'd10;
  localparam logic [PhaseW-1:0] PhSbHigh = 4'd11;
  localparam logic [PhaseW-1:0] PhRbLow  = 4'd12;
  localparam logic [PhaseW-1:0] PhRbHigh = 4'd13;
  localparam logic [PhaseW-1:0] PhRaLow  = 4'd14;
  localparam logic [PhaseW-1:0] PhRaHigh = 4'd15;

  // register indexes (paddr[2])
  localparam logic RegTicksPerUnit = 1'b0;
  localparam logic RegAckTimeout   = 1'b1;

  // register reset values
  localparam logic [TickW-1:0] TicksPerUnitRst = 12'd100;
  localparam logic [TmoW-1:0]  AckTimeoutRst   = 8'd250;

  // bits per byte on the bus
  localparam logic [BitCntW-1:0] BitsPerByte = 4'd8;

  // one result item
  typedef struct packed {
    logic             scl_level;
    logic             sda_drive;
    logic             sda_output_enable;
    logic             busy_res;
    logic             done_res;
    logic [ByteW-1:0] rx_byte;
    logic             ack_error;
  } res_t;

endpackage

[src/i2cms_cmd_if.sv]
// ----------------------------------------------------------------------------
// i2cms_cmd_if
// Command channel: one item per bus tick, with command and sampled SDA level.
// ----------------------------------------------------------------------------
interface i2cms_cmd_if
  import i2cms_pkg::*;
();
  logic             valid;
  logic             ready;
  logic             cmd_valid;
  logic [ModeW-1:0] mode;
  logic [ByteW-1:0] tx_byte;
  logic             ack_after_read;
  logic             sda_in;

  modport source (
    output valid, cmd_valid, mode, tx_byte, ack_after_read, sda_in,
    input  ready
  );

  modport sink (
    input  valid, cmd_valid, mode, tx_byte, ack_after_read, sda_in,
    output ready
  );
endinterface

[src/i2cms_res_if.sv]
// ----------------------------------------------------------------------------
// i2cms_res_if
// Result channel: pin drive and status after each bus tick.
// ----------------------------------------------------------------------------
interface i2cms_res_if
  import i2cms_pkg::*;
();
  logic             valid;
  logic             ready;
  logic             scl_level;
  logic             sda_drive;
  logic             sda_output_enable;
  logic             busy_res;
  logic             done_res;
  logic [ByteW-1:0] rx_byte;
  logic             ack_error;

  modport source (
    output valid, scl_level, sda_drive, sda_output_enable, busy_res, done_res,
           rx_byte, ack_error,
    input  ready
  );

  modport sink (
    input  valid, scl_level, sda_drive, sda_output_enable, busy_res, done_res,
           rx_byte, ack_error,
    output ready
  );
endinterface

[src/i2c_master_bit_sequencer.sv]
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer
// I2C master pin sequencer stepped once per item: start, stop, send byte,
// wait ack and read byte, with delay units and acknowledge timeout.
// ----------------------------------------------------------------------------
// Pipeline: an accepted item goes into the input register, then the step logic
//   writes the result register; the sequencer state updates in one pass.
// Throughput: 1 item per cycle unless a held result stalls on res_o.ready.
// Reset: rst_ni asynchronous active low; pipeline empties, sequencer idles
//   with SCL/SDA high and driven, registers return to 100 and 250.
// ----------------------------------------------------------------------------
module i2c_master_bit_sequencer
  import i2cms_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ApbAw-1:0]  paddr,
  input  logic [ApbDw-1:0]  pwdata,
  output logic [ApbDw-1:0]  prdata,
  output logic              pready,
  // channels
  i2cms_cmd_if.sink         cmd_i,
  i2cms_res_if.source       res_o
);

  // configuration registers
  logic [TickW-1:0] tpu_q;
  logic [TmoW-1:0]  tmo_q;
  logic             cfg_wr;

  // input register stage
  logic             in_valid_q;
  logic             in_cmd_valid_q;
  logic [ModeW-1:0] in_mode_q;
  logic [ByteW-1:0] in_tx_q;
  logic             in_ack_q;
  logic             in_sda_q;

  // result register stage
  logic             res_valid_q;
  res_t             res_q;
  res_t             res_d;
  logic             out_free;
  logic             step;

  // sequencer state
  logic [PhaseW-1:0]  phase_q, phase_d;
  logic [DelayW-1:0]  delay_q, delay_d;
  logic [BitCntW-1:0] bit_q, bit_d;
  logic [ByteW-1:0]   shift_q, shift_d;
  logic               scl_q, scl_d;
  logic               sda_q, sda_d;
  logic               oe_q, oe_d;
  logic               ack_sel_q, ack_sel_d;
  logic [TmoW-1:0]    awc_q, awc_d;
  logic               err_q, err_d;
  logic [ByteW-1:0]   rx_q, rx_d;
  logic               done_d;

  // delay loads for one and two units
  logic [DelayW-1:0]  one_unit;
  logic [DelayW-1:0]  two_units;

  assign one_unit  = {1'b0, tpu_q};
  assign two_units = {tpu_q, 1'b0};

  // apb register access
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    prdata = '0;
    case (paddr[2])
      RegTicksPerUnit: prdata = {{(ApbDw-TickW){1'b0}}, tpu_q};
      RegAckTimeout:   prdata = {{(ApbDw-TmoW){1'b0}}, tmo_q};
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpu_q <= TicksPerUnitRst;
      tmo_q <= AckTimeoutRst;
    end else if (cfg_wr) begin
      if (paddr[2] == RegTicksPerUnit) tpu_q <= pwdata[TickW-1:0];
      else                             tmo_q <= pwdata[TmoW-1:0];
    end
  end

  // pipeline handshake
  assign out_free    = !res_valid_q || res_o.ready;
  assign step        = in_valid_q && out_free;
  assign cmd_i.ready = !in_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (cmd_i.ready) begin
      in_valid_q <= cmd_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ready && cmd_i.valid) begin
      in_cmd_valid_q <= cmd_i.cmd_valid;
      in_mode_q      <= cmd_i.mode;
      in_tx_q        <= cmd_i.tx_byte;
      in_ack_q       <= cmd_i.ack_after_read;
      in_sda_q       <= cmd_i.sda_in;
    end
  end

  // one sequencer tick
  always_comb begin
    logic             do_poll;
    logic [TmoW-1:0]  poll_base;
    logic [TmoW:0]    poll_next;
    logic [BitCntW-1:0] bit_inc;
    logic [ByteW-1:0] shift_in;

    phase_d   = phase_q;
    delay_d   = delay_q;
    bit_d     = bit_q;
    shift_d   = shift_q;
    scl_d     = scl_q;
    sda_d     = sda_q;
    oe_d      = oe_q;
    ack_sel_d = ack_sel_q;
    awc_d     = awc_q;
    err_d     = err_q;
    rx_d      = rx_q;
    done_d    = 1'b0;
    do_poll   = 1'b0;
    poll_base = awc_q;
    bit_inc   = bit_q + 1'b1;
    shift_in  = {shift_q[ByteW-2:0], in_sda_q};

    if (phase_q == PhIdle) begin
      // command accept
      if (in_cmd_valid_q) begin
        case (in_mode_q)
          CmdStart: begin
            oe_d = 1'b1; sda_d = 1'b1; scl_d = 1'b1;
            phase_d = PhStA; delay_d = two_units;
          end
          CmdStop: begin
            oe_d = 1'b1; scl_d = 1'b0; sda_d = 1'b0;
            phase_d = PhSpA; delay_d = two_units;
          end
          CmdSendByte: begin
            oe_d = 1'b1; shift_d = in_tx_q; bit_d = '0; scl_d = 1'b0;
            phase_d = PhSbLow; delay_d = one_unit;
          end
          CmdWaitAck: begin
            err_d = 1'b0; oe_d = 1'b0; scl_d = 1'b0;
            phase_d = PhWaA; delay_d = one_unit;
          end
          CmdReadByte: begin
            oe_d = 1'b0; bit_d = '0; shift_d = '0;
            ack_sel_d = in_ack_q; scl_d = 1'b0;
            phase_d = PhRbLow; delay_d = two_units;
          end
          default: ;
        endcase
      end
    end else if (phase_q == PhWaPoll) begin
      do_poll = 1'b1;
    end else if (delay_q > DelayW'(1)) begin
      delay_d = delay_q - 1'b1;
    end else begin
      // phase advance at end of delay
      case (phase_q)
        PhStA:    begin sda_d = 1'b0; phase_d = PhStB; delay_d = two_units; end
        PhStB:    begin scl_d = 1'b0; phase_d = PhIdle; delay_d = '0; done_d = 1'b1; end
        PhSpA:    begin scl_d = 1'b1; phase_d = PhSpB; delay_d = one_unit; end
        PhSpB:    begin sda_d = 1'b1; phase_d = PhSpC; delay_d = two_units; end
        PhSpC:    begin phase_d = PhIdle; delay_d = '0; done_d = 1'b1; end
        PhWaA:    begin scl_d = 1'b1; phase_d = PhWaB; delay_d = one_unit; end
        PhWaB: begin
          awc_d = '0; phase_d = PhWaPoll; delay_d = '0;
          poll_base = '0; do_poll = 1'b1;
        end
        PhSbLow: begin
          sda_d = shift_q[ByteW-1];
          shift_d = {shift_q[ByteW-2:0], 1'b0};
          phase_d = PhSbData; delay_d = one_unit;
        end
        PhSbData: begin scl_d = 1'b1; phase_d = PhSbHigh; delay_d = two_units; end
        PhSbHigh: begin
          bit_d = bit_inc; scl_d = 1'b0;
          if (bit_inc >= BitsPerByte) begin
            phase_d = PhIdle; delay_d = '0; done_d = 1'b1;
          end else begin
            phase_d = PhSbLow; delay_d = one_unit;
          end
        end
        PhRbLow: begin scl_d = 1'b1; phase_d = PhRbHigh; delay_d = two_units; end
        PhRbHigh: begin
          shift_d = shift_in; bit_d = bit_inc; scl_d = 1'b0;
          if (bit_inc >= BitsPerByte) begin
            rx_d = shift_in; oe_d = 1'b1; sda_d = !ack_sel_q;
            phase_d = PhRaLow; delay_d = two_units;
          end else begin
            phase_d = PhRbLow; delay_d = two_units;
          end
        end
        PhRaLow:  begin scl_d = 1'b1; phase_d = PhRaHigh; delay_d = two_units; end
        PhRaHigh: begin scl_d = 1'b0; phase_d = PhIdle; delay_d = '0; done_d = 1'b1; end
        default:  begin phase_d = PhIdle; delay_d = '0; end
      endcase
    end

    // acknowledge poll with timeout into stop
    poll_next = {1'b0, poll_base} + 1'b1;
    if (do_poll) begin
      if (!in_sda_q) begin
        scl_d = 1'b0; phase_d = PhIdle; delay_d = '0; done_d = 1'b1;
      end else if (poll_next > {1'b0, tmo_q}) begin
        err_d = 1'b1; oe_d = 1'b1; scl_d = 1'b0; sda_d = 1'b0;
        phase_d = PhSpA; delay_d = two_units;
      end else begin
        awc_d = poll_next[TmoW-1:0];
      end
    end
  end

  // result item from the next state
  always_comb begin
    res_d.scl_level         = scl_d;
    res_d.sda_drive         = sda_d;
    res_d.sda_output_enable = oe_d;
    res_d.busy_res          = (phase_d != PhIdle);
    res_d.done_res          = done_d;
    res_d.rx_byte           = rx_d;
    res_d.ack_error         = err_d;
  end

  // sequencer state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhIdle;
      delay_q   <= '0;
      bit_q     <= '0;
      shift_q   <= '0;
      scl_q     <= 1'b1;
      sda_q     <= 1'b1;
      oe_q      <= 1'b1;
      ack_sel_q <= 1'b0;
      awc_q     <= '0;
      err_q     <= 1'b0;
      rx_q      <= '0;
    end else if (step) begin
      phase_q   <= phase_d;
      delay_q   <= delay_d;
      bit_q     <= bit_d;
      shift_q   <= shift_d;
      scl_q     <= scl_d;
      sda_q     <= sda_d;
      oe_q      <= oe_d;
      ack_sel_q <= ack_sel_d;
      awc_q     <= awc_d;
      err_q     <= err_d;
      rx_q      <= rx_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (out_free) begin
      res_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid             = res_valid_q;
  assign res_o.scl_level         = res_q.scl_level;
  assign res_o.sda_drive         = res_q.sda_drive;
  assign res_o.sda_output_enable = res_q.sda_output_enable;
  assign res_o.busy_res          = res_q.busy_res;
  assign res_o.done_res          = res_q.done_res;
  assign res_o.rx_byte           = res_q.rx_byte;
  assign res_o.ack_error         = res_q.ack_error;

  // checks
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_q.done_res |-> !res_q.busy_res)
    else $error("done item reports busy");

  a_idle_no_delay: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhIdle) || (phase_q == PhWaPoll) |-> (delay_q == '0))
    else $error("delay pending in idle or poll phase");

  a_bit_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bit_q <= BitsPerByte)
    else $error("bit counter beyond one byte");

endmodule

[tb/i2c_master_bit_sequencer_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer_tb
// Self-checking bench for the I2C pin sequencer. Every accepted item is one
// bus tick: a local model of the sequencer steps on it and queues the pin
// drive and status it predicts. Each result item is then compared field by
// field against that queue. Directed runs cover reset defaults, every command,
// busy and unknown commands, zero and longer delay units, and zero and
// maximum acknowledge timeouts. Random runs follow with mostly well-formed
// bus traffic, noise, sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module i2c_master_bit_sequencer_tb;
  import i2cms_pkg::*;

  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned MaxPrinted = 40;

  logic             clk_i;
  logic             rst_ni;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [ApbAw-1:0] paddr;
  logic [ApbDw-1:0] pwdata;
  logic [ApbDw-1:0] prdata;
  logic             pready;

  i2cms_cmd_if cmd_if ();
  i2cms_res_if res_if ();

  i2c_master_bit_sequencer u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cmd_i   (cmd_if),
    .res_o   (res_if)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // sequencer model: state, configuration and expected pin/status items
  // ---------------------------------------------------------------------------
  logic [PhaseW-1:0]  ph;
  logic [DelayW-1:0]  dly;
  logic [BitCntW-1:0] nbits;
  logic [ByteW-1:0]   shreg;
  logic               scl_q;
  logic               sda_q;
  logic               oe_q;
  logic               ack_pick;
  logic [TmoW-1:0]    polls;
  logic               err_q;
  logic               done_q;
  logic [ByteW-1:0]   rx_q;
  logic [TickW-1:0]   cfg_ticks;
  logic [TmoW-1:0]    cfg_tmo;

  res_t exp_pins_q[$];
  res_t want_pins;

  int unsigned items_sent;
  int unsigned results_seen;
  int unsigned errors;
  int unsigned cycle_count;

  // idling controls
  logic             send_gaps;
  logic             recv_stalls;
  int unsigned      burst_left;
  logic [7:0]       stall_pat;
  logic [2:0]       stall_idx;
  logic             bus_open;

  function automatic void bus_reset();
    ph        = PhIdle;
    dly       = '0;
    nbits     = '0;
    shreg     = '0;
    scl_q     = 1'b1;
    sda_q     = 1'b1;
    oe_q      = 1'b1;
    ack_pick  = 1'b0;
    polls     = '0;
    err_q     = 1'b0;
    done_q    = 1'b0;
    rx_q      = '0;
    cfg_ticks = TicksPerUnitRst;
    cfg_tmo   = AckTimeoutRst;
  endfunction

  // enter a phase that lasts units delay units
  function automatic void hold(logic [PhaseW-1:0] nxt, int units);
    ph  = nxt;
    dly = DelayW'(units * int'(cfg_ticks));
  endfunction

  function automatic void end_cmd();
    ph     = PhIdle;
    dly    = '0;
    done_q = 1'b1;
  endfunction

  function automatic void open_stop();
    oe_q  = 1'b1;
    scl_q = 1'b0;
    sda_q = 1'b0;
    hold(PhSpA, 2);
  endfunction

  // low sda acknowledges; too many high polls force a stop with error
  function automatic void poll_sda(logic sda);
    int n;
    if (!sda) begin
      scl_q = 1'b0;
      end_cmd();
    end else begin
      n = int'(polls) + 1;
      if (n > int'(cfg_tmo)) begin
        err_q = 1'b1;
        open_stop();
      end else begin
        polls = TmoW'(n);
      end
    end
  endfunction

  function automatic void advance_phase(logic sda);
    case (ph)
      PhStA: begin
        sda_q = 1'b0;
        hold(PhStB, 2);
      end
      PhStB: begin
        scl_q = 1'b0;
        end_cmd();
      end
      PhSpA: begin
        scl_q = 1'b1;
        hold(PhSpB, 1);
      end
      PhSpB: begin
        sda_q = 1'b1;
        hold(PhSpC, 2);
      end
      PhSpC: end_cmd();
      PhWaA: begin
        scl_q = 1'b1;
        hold(PhWaB, 1);
      end
      PhWaB: begin
        polls = '0;
        ph    = PhWaPoll;
        dly   = '0;
        poll_sda(sda);
      end
      PhSbLow: begin
        sda_q = shreg[ByteW-1];
        shreg = {shreg[ByteW-2:0], 1'b0};
        hold(PhSbData, 1);
      end
      PhSbData: begin
        scl_q = 1'b1;
        hold(PhSbHigh, 2);
      end
      PhSbHigh: begin
        nbits = nbits + 1'b1;
        scl_q = 1'b0;
        if (nbits >= BitsPerByte) end_cmd();
        else hold(PhSbLow, 1);
      end
      PhRbLow: begin
        scl_q = 1'b1;
        hold(PhRbHigh, 2);
      end
      PhRbHigh: begin
        shreg = {shreg[ByteW-2:0], sda};
        nbits = nbits + 1'b1;
        scl_q = 1'b0;
        if (nbits >= BitsPerByte) begin
          rx_q  = shreg;
          oe_q  = 1'b1;
          sda_q = ~ack_pick;
          hold(PhRaLow, 2);
        end else begin
          hold(PhRbLow, 2);
        end
      end
      PhRaLow: begin
        scl_q = 1'b1;
        hold(PhRaHigh, 2);
      end
      PhRaHigh: begin
        scl_q = 1'b0;
        end_cmd();
      end
      default: begin
        ph  = PhIdle;
        dly = '0;
      end
    endcase
  endfunction

  function automatic void start_cmd(logic [ModeW-1:0] mode, logic [ByteW-1:0] tx,
                                    logic ack);
    case (mode)
      CmdStart: begin
        oe_q  = 1'b1;
        sda_q = 1'b1;
        scl_q = 1'b1;
        hold(PhStA, 2);
      end
      CmdStop: open_stop();
      CmdSendByte: begin
        oe_q  = 1'b1;
        shreg = tx;
        nbits = '0;
        scl_q = 1'b0;
        hold(PhSbLow, 1);
      end
      CmdWaitAck: begin
        err_q = 1'b0;
        oe_q  = 1'b0;
        scl_q = 1'b0;
        hold(PhWaA, 1);
      end
      default: begin
        oe_q     = 1'b0;
        nbits    = '0;
        shreg    = '0;
        ack_pick = ack;
        scl_q    = 1'b0;
        hold(PhRbLow, 2);
      end
    endcase
  endfunction

  // one bus tick: returns the pins and status after the tick
  function automatic res_t step_bus(logic cv, logic [ModeW-1:0] mode,
                                    logic [ByteW-1:0] tx, logic ack, logic sda);
    res_t r;
    done_q = 1'b0;
    if (ph == PhIdle) begin
      if (cv && mode <= CmdReadByte) start_cmd(mode, tx, ack);
    end else if (ph == PhWaPoll) begin
      poll_sda(sda);
    end else if (dly > 1) begin
      dly = dly - 1'b1;
    end else begin
      advance_phase(sda);
    end
    r.scl_level         = scl_q;
    r.sda_drive         = sda_q;
    r.sda_output_enable = oe_q;
    r.busy_res          = (ph != PhIdle);
    r.done_res          = done_q;
    r.rx_byte           = rx_q;
    r.ack_error         = err_q;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // error reporting and result checking
  // ---------------------------------------------------------------------------
  task automatic flag_error(string msg);
    errors++;
    if (errors <= MaxPrinted) $display("%0t ns: error: %s", $time, msg);
  endtask

  task automatic compare_field(string name, logic [ByteW-1:0] got,
                               logic [ByteW-1:0] want);
    if (got !== want)
      flag_error($sformatf("result %0d %s got %0h want %0h", results_seen, name, got,
                           want));
  endtask

  // result checker and receiver stall pattern
  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (exp_pins_q.size() == 0) begin
        flag_error("result item with no expectation waiting");
      end else begin
        want_pins = exp_pins_q.pop_front();
        compare_field("scl_level", res_if.scl_level, want_pins.scl_level);
        compare_field("sda_drive", res_if.sda_drive, want_pins.sda_drive);
        compare_field("sda_output_enable", res_if.sda_output_enable,
                      want_pins.sda_output_enable);
        compare_field("busy_res", res_if.busy_res, want_pins.busy_res);
        compare_field("done_res", res_if.done_res, want_pins.done_res);
        compare_field("rx_byte", res_if.rx_byte, want_pins.rx_byte);
        compare_field("ack_error", res_if.ack_error, want_pins.ack_error);
      end
      results_seen++;
    end
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      stall_idx    <= '0;
    end else if (recv_stalls) begin
      res_if.ready <= stall_pat[stall_idx];
      stall_idx    <= stall_idx + 1'b1;
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic set_idling(logic snd, logic rcv);
    send_gaps   = snd;
    recv_stalls = rcv;
    stall_pat   = 8'($urandom_range(1, 255));
    burst_left  = $urandom_range(1, 12);
  endtask

  // offer one tick item, model it once accepted, then maybe pause
  task automatic send_tick(logic cv, logic [ModeW-1:0] mode, logic [ByteW-1:0] tx,
                           logic ack, logic sda);
    int unsigned gap;
    cmd_if.valid          <= 1'b1;
    cmd_if.cmd_valid      <= cv;
    cmd_if.mode           <= mode;
    cmd_if.tx_byte        <= tx;
    cmd_if.ack_after_read <= ack;
    cmd_if.sda_in         <= sda;
    do @(posedge clk_i); while (!cmd_if.ready);
    exp_pins_q.push_back(step_bus(cv, mode, tx, ack, sda));
    items_sent++;
    if (send_gaps) begin
      if (burst_left == 0) begin
        gap        = $urandom_range(1, 4);
        burst_left = $urandom_range(1, 12);
        cmd_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end else begin
        burst_left--;
      end
    end
  endtask

  // tick until the sequencer is idle; busy ticks carry ignored commands
  task automatic drain_cmd(int unsigned zero_pct);
    while (ph != PhIdle)
      send_tick(1'($urandom_range(0, 1)), ModeW'($urandom_range(0, 7)),
                ByteW'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                ($urandom_range(0, 99) < zero_pct) ? 1'b0 : 1'b1);
  endtask

  task automatic run_cmd(logic [ModeW-1:0] mode, logic [ByteW-1:0] tx, logic ack,
                         int unsigned zero_pct);
    send_tick(1'b1, mode, tx, ack, 1'($urandom_range(0, 1)));
    drain_cmd(zero_pct);
  endtask

  // sequencer idle, all results in and the pipeline empty
  task automatic settle();
    drain_cmd(50);
    cmd_if.valid <= 1'b0;
    while (exp_pins_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apb_access(logic idx, logic wr, logic [ApbDw-1:0] wdata,
                            output logic [ApbDw-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic check_register(logic idx, logic [ApbDw-1:0] want);
    logic [ApbDw-1:0] rd;
    apb_access(idx, 1'b0, '0, rd);
    if (rd !== want)
      flag_error($sformatf("register %0d read %0h want %0h", idx, rd, want));
  endtask

  task automatic set_config(logic [TickW-1:0] ticks, logic [TmoW-1:0] tmo);
    logic [ApbDw-1:0] rd;
    settle();
    apb_access(RegTicksPerUnit, 1'b1, ApbDw'(ticks), rd);
    check_register(RegTicksPerUnit, ApbDw'(ticks));
    apb_access(RegAckTimeout, 1'b1, ApbDw'(tmo), rd);
    check_register(RegAckTimeout, ApbDw'(tmo));
    cfg_ticks = ticks;
    cfg_tmo   = tmo;
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  // reset register values and idle pin levels
  task automatic test_reset_defaults();
    check_register(RegTicksPerUnit, ApbDw'(TicksPerUnitRst));
    check_register(RegAckTimeout, ApbDw'(AckTimeoutRst));
    set_idling(1'b1, 1'b1);
    send_tick(1'b0, CmdStart, 8'h00, 1'b0, 1'b1);
    send_tick(1'b0, CmdReadByte, 8'hFF, 1'b1, 1'b0);
  endtask

  // every command, byte extremes, ack and timeout, ignored commands
  task automatic test_commands();
    int m;
    set_config(TickW'(1), TmoW'(3));
    set_idling(1'b0, 1'b0);
    run_cmd(CmdStart, '0, 1'b0, 50);
    run_cmd(CmdSendByte, 8'h00, 1'b0, 50);
    run_cmd(CmdWaitAck, '0, 1'b0, 100);
    run_cmd(CmdSendByte, 8'hFF, 1'b1, 50);
    // slave never acknowledges: stop with error
    run_cmd(CmdWaitAck, '0, 1'b0, 0);
    run_cmd(CmdStart, '0, 1'b0, 50);
    run_cmd(CmdReadByte, 8'hFF, 1'b1, 50);
    run_cmd(CmdReadByte, 8'h00, 1'b0, 50);
    // unknown modes and an idle tick with a valid mode are ignored
    for (m = int'(CmdReadByte) + 1; m < (1 << ModeW); m++)
      send_tick(1'b1, ModeW'(m), 8'hFF, 1'b1, 1'b1);
    send_tick(1'b0, CmdStart, 8'h00, 1'b0, 1'b0);
    run_cmd(CmdSendByte, 8'hA5, 1'b0, 50);
    run_cmd(CmdStop, '0, 1'b0, 50);
  endtask

  // zero delay unit and zero timeout: first high poll fails
  task automatic test_zero_settings();
    set_config('0, '0);
    set_idling(1'b1, 1'b0);
    run_cmd(CmdStart, '0, 1'b0, 50);
    run_cmd(CmdWaitAck, '0, 1'b0, 0);
    run_cmd(CmdWaitAck, '0, 1'b0, 100);
    run_cmd(CmdSendByte, 8'h5A, 1'b0, 50);
    run_cmd(CmdReadByte, 8'h00, 1'b1, 50);
    run_cmd(CmdStop, '0, 1'b0, 50);
  endtask

  // longest acknowledge timeout
  task automatic test_max_timeout();
    set_config('0, {TmoW{1'b1}});
    set_idling(1'b0, 1'b1);
    run_cmd(CmdWaitAck, '0, 1'b0, 0);
    run_cmd(CmdWaitAck, '0, 1'b0, 100);
  endtask

  // longer delay unit: holds count down over many ticks
  task automatic test_long_delay();
    set_config(TickW'(23), TmoW'(1));
    set_idling(1'b1, 1'b1);
    run_cmd(CmdStart, '0, 1'b0, 50);
  endtask

  // mostly well-formed transfers with some noise
  task automatic run_traffic(int unsigned n);
    int unsigned mark;
    int unsigned pick;
    mark = items_sent;
    while (items_sent - mark < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        send_tick(1'($urandom_range(0, 1)), ModeW'($urandom_range(0, 7)),
                  ByteW'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
        drain_cmd(30);
      end else if (!bus_open || pick < 22) begin
        run_cmd(CmdStart, '0, 1'b0, 50);
        bus_open = 1'b1;
      end else if (pick < 32) begin
        run_cmd(CmdStop, '0, 1'b0, 50);
        bus_open = 1'b0;
      end else if (pick < 60) begin
        run_cmd(CmdSendByte, ByteW'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 50);
      end else if (pick < 78) begin
        run_cmd(CmdWaitAck, '0, 1'b0, $urandom_range(0, 1) ? 4 : 25);
      end else begin
        run_cmd(CmdReadByte, ByteW'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                50);
      end
    end
  endtask

  task automatic test_random_traffic();
    int p;
    for (p = 0; p < 5; p++) begin
      set_config((p == 4) ? TickW'($urandom_range(4, 6)) : TickW'($urandom_range(0, 3)),
                 (p == 2) ? {TmoW{1'b1}} : TmoW'($urandom_range(0, 12)));
      set_idling(p[0], p[1]);
      bus_open = 1'b0;
      run_traffic(60);
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni                <= 1'b0;
    psel                  <= 1'b0;
    penable               <= 1'b0;
    pwrite                <= 1'b0;
    paddr                 <= '0;
    pwdata                <= '0;
    cmd_if.valid          <= 1'b0;
    cmd_if.cmd_valid      <= 1'b0;
    cmd_if.mode           <= CmdStart;
    cmd_if.tx_byte        <= '0;
    cmd_if.ack_after_read <= 1'b0;
    cmd_if.sda_in         <= 1'b1;
    items_sent   = 0;
    results_seen = 0;
    errors       = 0;
    cycle_count  = 0;
    bus_open     = 1'b0;
    set_idling(1'b0, 1'b0);
    bus_reset();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_commands();
    test_zero_settings();
    test_max_timeout();
    test_long_delay();
    test_random_traffic();

    settle();
    repeat (6) @(posedge clk_i);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[i2c_master_bit_sequencer.f]
src/i2cms_pkg.sv
src/i2cms_cmd_if.sv
src/i2cms_res_if.sv
src/i2c_master_bit_sequencer.sv
tb/i2c_master_bit_sequencer_tb.sv
